// ===== src/drum_membrane_wave_step_unit_defines.svh =====
// assertion macros for the membrane wave step unit
`ifndef DRUM_MEMBRANE_WAVE_STEP_UNIT_DEFINES_SVH
`define DRUM_MEMBRANE_WAVE_STEP_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define DMWS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the cycle after
`define DMWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dmws_pkg.sv =====
// shared types and constants for the membrane wave step unit
`timescale 1ns / 1ps
`default_nettype none
package dmws_pkg;

    localparam int GRID_SIZE = 16;
    localparam int DATA_W    = 24;
    localparam int COEF_W    = 16;
    localparam int POS_W     = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic [COEF_W-1:0] TENSION_RST = 16'd32768;
    localparam logic [COEF_W-1:0] DAMPING_RST = 16'd13;
    localparam logic [COEF_W-1:0] RECIP_RST   = 16'd65523;
    localparam logic [COEF_W-1:0] GAIN_RST    = 16'd49152;
    localparam logic [POS_W-1:0]  PROBE_RST   = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TENSION   = 3'd0,
        CFG_DAMPING   = 3'd1,
        CFG_RECIP     = 3'd2,
        CFG_GAIN      = 3'd3,
        CFG_PROBE_ROW = 3'd4,
        CFG_PROBE_COL = 3'd5
    } cfg_idx_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_START,
        OP_CLEAR,
        OP_STRIKE,
        OP_WEST,
        OP_CENTER,
        OP_CAP_N,
        OP_CAP_S,
        OP_CAP_E,
        OP_NUM,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_WR_CELL,
        OP_EDGE_MUL,
        OP_EDGE_WR,
        OP_SWAP,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   rd_probe;
        logic   zero;
    } dp_cmd_t;

endpackage
`default_nettype wire

// ===== src/dmws_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module dmws_ram #(
    parameter int Width = 24,
    parameter int Depth = 256,
    localparam int AddrW = $clog2(Depth)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AddrW-1:0] wr_addr,
    input  wire logic [Width-1:0] wr_data,
    input  wire logic [AddrW-1:0] rd_addr,
    output logic      [Width-1:0] rd_data
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== src/dmws_dp.sv =====
// datapath: grid banks, stencil arithmetic, config registers and result register
`timescale 1ns / 1ps
`default_nettype none
module dmws_dp #(
    parameter int GridSize = dmws_pkg::GRID_SIZE,
    localparam int AddrW = $clog2(GridSize * GridSize)
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire dmws_pkg::dp_cmd_t                 cmd,
    input  wire logic [AddrW-1:0]                  addr_prev,
    input  wire logic [AddrW-1:0]                  addr_new,
    input  wire logic [AddrW-1:0]                  wr_addr,
    input  wire logic signed [dmws_pkg::DATA_W-1:0] strike_value,
    input  wire logic                              cfg_valid,
    input  wire logic [dmws_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dmws_pkg::COEF_W-1:0]       cfg_data,
    output logic signed [dmws_pkg::DATA_W-1:0]     probe_value,
    output logic                                   saturated
);

    localparam int DW    = dmws_pkg::DATA_W;
    localparam int LAP_W = 28;
    localparam int MB_W  = 18;
    localparam int P_W   = LAP_W + MB_W;
    localparam int NUM_W = 44;
    localparam int LO_W  = 22;
    localparam int T_W   = LO_W + dmws_pkg::COEF_W;
    localparam int TOT_W = 62;
    localparam int Q_W   = 30;
    localparam logic signed [TOT_W-1:0] CELL_HALF = 62'sd2147483648;
    localparam logic signed [P_W-1:0]   EDGE_HALF = 46'sd32768;
    localparam logic signed [DW-1:0]    Q_MAX = 24'sh7FFFFF;
    localparam logic signed [DW-1:0]    Q_MIN = -24'sh800000;

    function automatic logic q_ovf(input logic signed [Q_W-1:0] v);
        q_ovf = (v[Q_W-1:DW-1] != {(Q_W-DW+1){v[DW-1]}});
    endfunction

    function automatic logic signed [DW-1:0] q_clamp(input logic signed [Q_W-1:0] v);
        if (q_ovf(v))
        begin
            q_clamp = v[Q_W-1] ? Q_MIN : Q_MAX;
        end
        else
        begin
            q_clamp = v[DW-1:0];
        end
    endfunction

    logic [dmws_pkg::COEF_W-1:0] tension_reg, damping_reg, recip_reg, gain_reg;
    logic [dmws_pkg::POS_W-1:0]  prow_reg, pcol_reg;
    logic                        sel_reg, sat_reg;

    logic signed [DW-1:0]    w_reg, c_reg, e_reg, strike_reg;
    logic signed [LAP_W-1:0] lap_reg;
    logic signed [NUM_W-1:0] acc_reg, num_reg;
    logic signed [P_W-1:0]   p_reg;
    logic [T_W-1:0]          t_reg;
    logic signed [DW-1:0]    probe_reg;
    logic                    sat_out_reg;

    logic [DW-1:0]           qa, qb, rd_prev, rd_new;
    logic [AddrW-1:0]        prev_addr, probe_addr, a_rd, b_rd;
    logic                    probe_ok;
    logic signed [LAP_W-1:0] mul_a, lap_sum;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [P_W-1:0]   mul_p, edge_sum;
    logic signed [TOT_W-1:0] cell_sum;
    logic signed [Q_W-1:0]   res_q;
    logic signed [DW-1:0]    res_val, wr_data_prev, wr_data_new;
    logic                    we_prev, we_new, a_we, b_we;
    logic [DW-1:0]           a_data, b_data;

    assign probe_ok   = (int'(prow_reg) < GridSize) && (int'(pcol_reg) < GridSize);
    assign probe_addr = AddrW'(int'(prow_reg) * GridSize + int'(pcol_reg));
    assign prev_addr  = cmd.rd_probe ? probe_addr : addr_prev;

    assign rd_prev = sel_reg ? qb : qa;
    assign rd_new  = sel_reg ? qa : qb;
    assign a_rd    = sel_reg ? addr_new : prev_addr;
    assign b_rd    = sel_reg ? prev_addr : addr_new;

    assign lap_sum = lap_reg + LAP_W'($signed(rd_prev));

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            dmws_pkg::OP_CAP_N:
            begin
                mul_a = LAP_W'($signed(rd_new));
                mul_b = MB_W'(32'd65536 - 32'(damping_reg));
            end
            dmws_pkg::OP_CAP_E:
            begin
                mul_a = lap_sum;
                mul_b = $signed({2'b00, tension_reg});
            end
            dmws_pkg::OP_MUL_LO:
            begin
                mul_a = $signed({6'b0, num_reg[LO_W-1:0]});
                mul_b = $signed({2'b00, recip_reg});
            end
            dmws_pkg::OP_MUL_HI:
            begin
                mul_a = LAP_W'($signed(num_reg[NUM_W-1:LO_W]));
                mul_b = $signed({2'b00, recip_reg});
            end
            dmws_pkg::OP_EDGE_MUL:
            begin
                mul_a = LAP_W'($signed(rd_new));
                mul_b = $signed({2'b00, gain_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign cell_sum = (TOT_W'(p_reg) <<< LO_W) + TOT_W'($signed({1'b0, t_reg})) + CELL_HALF;
    assign edge_sum = p_reg + EDGE_HALF;
    assign res_q    = (cmd.op == dmws_pkg::OP_WR_CELL) ? $signed(cell_sum[TOT_W-1:32])
                                                       : $signed(edge_sum[P_W-1:16]);
    assign res_val  = q_clamp(res_q);

    assign we_prev      = (cmd.op == dmws_pkg::OP_CLEAR) || (cmd.op == dmws_pkg::OP_STRIKE);
    assign we_new       = (cmd.op == dmws_pkg::OP_CLEAR) || (cmd.op == dmws_pkg::OP_WR_CELL)
                       || (cmd.op == dmws_pkg::OP_EDGE_WR);
    assign wr_data_prev = (cmd.op == dmws_pkg::OP_STRIKE) ? strike_reg : '0;
    assign wr_data_new  = (cmd.op == dmws_pkg::OP_CLEAR) ? '0 : res_val;

    assign a_we   = sel_reg ? we_new : we_prev;
    assign b_we   = sel_reg ? we_prev : we_new;
    assign a_data = sel_reg ? wr_data_new : wr_data_prev;
    assign b_data = sel_reg ? wr_data_prev : wr_data_new;

    dmws_ram #(
        .Width(DW),
        .Depth(GridSize * GridSize)
    ) u_bank_a (
        .clk     (clk),
        .we      (a_we),
        .wr_addr (wr_addr),
        .wr_data (a_data),
        .rd_addr (a_rd),
        .rd_data (qa)
    );

    dmws_ram #(
        .Width(DW),
        .Depth(GridSize * GridSize)
    ) u_bank_b (
        .clk     (clk),
        .we      (b_we),
        .wr_addr (wr_addr),
        .wr_data (b_data),
        .rd_addr (b_rd),
        .rd_data (qb)
    );

    // config registers, bank select and saturation flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tension_reg <= dmws_pkg::TENSION_RST;
            damping_reg <= dmws_pkg::DAMPING_RST;
            recip_reg   <= dmws_pkg::RECIP_RST;
            gain_reg    <= dmws_pkg::GAIN_RST;
            prow_reg    <= dmws_pkg::PROBE_RST;
            pcol_reg    <= dmws_pkg::PROBE_RST;
            sel_reg     <= 1'b0;
            sat_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    dmws_pkg::CFG_TENSION:   tension_reg <= cfg_data;
                    dmws_pkg::CFG_DAMPING:   damping_reg <= cfg_data;
                    dmws_pkg::CFG_RECIP:     recip_reg   <= cfg_data;
                    dmws_pkg::CFG_GAIN:      gain_reg    <= cfg_data;
                    dmws_pkg::CFG_PROBE_ROW: prow_reg    <= cfg_data[dmws_pkg::POS_W-1:0];
                    dmws_pkg::CFG_PROBE_COL: pcol_reg    <= cfg_data[dmws_pkg::POS_W-1:0];
                    default:                 ;
                endcase
            end
            if (cmd.op == dmws_pkg::OP_SWAP)
            begin
                sel_reg <= ~sel_reg;
            end
            if (cmd.op == dmws_pkg::OP_START)
            begin
                sat_reg <= 1'b0;
            end
            else if ((cmd.op == dmws_pkg::OP_WR_CELL) || (cmd.op == dmws_pkg::OP_EDGE_WR))
            begin
                sat_reg <= sat_reg | q_ovf(res_q);
            end
        end
    end

    // arithmetic pipeline registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            dmws_pkg::OP_START:
            begin
                strike_reg <= strike_value;
            end
            dmws_pkg::OP_WEST:
            begin
                w_reg <= rd_prev;
            end
            dmws_pkg::OP_CENTER:
            begin
                c_reg <= rd_prev;
            end
            dmws_pkg::OP_CAP_N:
            begin
                lap_reg <= LAP_W'(w_reg) - (LAP_W'(c_reg) <<< 2) + LAP_W'($signed(rd_prev));
                p_reg   <= mul_p;
            end
            dmws_pkg::OP_CAP_S:
            begin
                lap_reg <= lap_sum;
                acc_reg <= (NUM_W'(c_reg) <<< 17) - NUM_W'(p_reg);
            end
            dmws_pkg::OP_CAP_E:
            begin
                p_reg <= mul_p;
                e_reg <= rd_prev;
            end
            dmws_pkg::OP_NUM:
            begin
                num_reg <= acc_reg + NUM_W'(p_reg);
            end
            dmws_pkg::OP_MUL_LO:
            begin
                p_reg <= mul_p;
            end
            dmws_pkg::OP_MUL_HI:
            begin
                t_reg <= p_reg[T_W-1:0];
                p_reg <= mul_p;
            end
            dmws_pkg::OP_WR_CELL:
            begin
                w_reg <= c_reg;
                c_reg <= e_reg;
            end
            dmws_pkg::OP_EDGE_MUL:
            begin
                p_reg <= mul_p;
            end
            dmws_pkg::OP_RESULT:
            begin
                probe_reg   <= (cmd.zero || !probe_ok) ? '0 : rd_prev;
                sat_out_reg <= cmd.zero ? 1'b0 : sat_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign probe_value = probe_reg;
    assign saturated   = sat_out_reg;

endmodule
`default_nettype wire

// ===== src/dmws_ctrl.sv =====
// controller: sequences clear, strike, stencil, edge and probe passes
`timescale 1ns / 1ps
`default_nettype none
module dmws_ctrl #(
    parameter int GridSize = dmws_pkg::GRID_SIZE,
    localparam int AddrW = $clog2(GridSize * GridSize)
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           kind,
    input  wire logic [dmws_pkg::POS_W-1:0]     strike_row,
    input  wire logic [dmws_pkg::POS_W-1:0]     strike_col,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output dmws_pkg::dp_cmd_t                   cmd,
    output logic [AddrW-1:0]                    addr_prev,
    output logic [AddrW-1:0]                    addr_new,
    output logic [AddrW-1:0]                    wr_addr
);

    localparam int RowW = $clog2(GridSize);
    localparam logic [RowW-1:0]  ONE        = RowW'(1);
    localparam logic [RowW-1:0]  ZERO       = '0;
    localparam logic [RowW-1:0]  LAST_IDX   = RowW'(GridSize - 1);
    localparam logic [RowW-1:0]  INNER_LAST = RowW'(GridSize - 2);
    localparam logic [RowW-1:0]  LAST_CORNER = RowW'(3);
    localparam logic [AddrW-1:0] LAST_CELL  = AddrW'(GridSize * GridSize - 1);

    typedef enum logic [4:0] {
        ST_CLR, ST_IDLE, ST_STRIKE,
        ST_RS0, ST_RS1, ST_RS2,
        ST_C0, ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6, ST_C7,
        ST_E0, ST_E1, ST_E2,
        ST_SWAP, ST_PROBE, ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        SIDE_TOP, SIDE_BOT, SIDE_LEFT, SIDE_RIGHT, SIDE_CORNER
    } side_t;

    function automatic logic [AddrW-1:0] cell_addr(input logic [RowW-1:0] r,
                                                   input logic [RowW-1:0] c);
        cell_addr = AddrW'(int'(r) * GridSize + int'(c));
    endfunction

    state_t                     state_reg, state_next;
    side_t                      side_reg, side_next;
    logic [RowW-1:0]            row_reg, row_next, col_reg, col_next;
    logic [AddrW-1:0]           cnt_reg, cnt_next;
    logic                       strike_reg, strike_next;
    logic [dmws_pkg::POS_W-1:0] srow_reg, srow_next, scol_reg, scol_next;
    logic                       out_valid_reg, out_valid_next;
    logic [RowW-1:0]            src_r, src_c, dst_r, dst_c;

    always_comb
    begin
        src_r = ONE;
        src_c = col_reg;
        dst_r = ZERO;
        dst_c = col_reg;
        case (side_reg)
            SIDE_TOP:
            begin
                src_r = ONE;        src_c = col_reg;
                dst_r = ZERO;       dst_c = col_reg;
            end
            SIDE_BOT:
            begin
                src_r = INNER_LAST; src_c = col_reg;
                dst_r = LAST_IDX;   dst_c = col_reg;
            end
            SIDE_LEFT:
            begin
                src_r = col_reg;    src_c = ONE;
                dst_r = col_reg;    dst_c = ZERO;
            end
            SIDE_RIGHT:
            begin
                src_r = col_reg;    src_c = INNER_LAST;
                dst_r = col_reg;    dst_c = LAST_IDX;
            end
            SIDE_CORNER:
            begin
                case (col_reg[1:0])
                    2'd0:
                    begin
                        src_r = ONE;        src_c = ZERO;
                        dst_r = ZERO;       dst_c = ZERO;
                    end
                    2'd1:
                    begin
                        src_r = INNER_LAST; src_c = ZERO;
                        dst_r = LAST_IDX;   dst_c = ZERO;
                    end
                    2'd2:
                    begin
                        src_r = ZERO;       src_c = INNER_LAST;
                        dst_r = ZERO;       dst_c = LAST_IDX;
                    end
                    default:
                    begin
                        src_r = LAST_IDX;   src_c = INNER_LAST;
                        dst_r = LAST_IDX;   dst_c = LAST_IDX;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        side_next      = side_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        cnt_next       = cnt_reg;
        strike_next    = strike_reg;
        srow_next      = srow_reg;
        scol_next      = scol_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = dmws_pkg::OP_NOP;
        cmd.rd_probe   = 1'b0;
        cmd.zero       = 1'b0;
        addr_prev      = '0;
        addr_new       = '0;
        wr_addr        = '0;
        case (state_reg)
            ST_CLR:
            begin
                cmd.op  = dmws_pkg::OP_CLEAR;
                wr_addr = cnt_reg;
                if (cnt_reg == LAST_CELL)
                begin
                    cnt_next   = '0;
                    state_next = strike_reg ? ST_STRIKE : ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + AddrW'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op      = dmws_pkg::OP_START;
                    strike_next = kind;
                    srow_next   = strike_row;
                    scol_next   = strike_col;
                    row_next    = ONE;
                    state_next  = kind ? ST_CLR : ST_RS0;
                end
            end
            ST_STRIKE:
            begin
                if ((int'(srow_reg) < GridSize) && (int'(scol_reg) < GridSize))
                begin
                    cmd.op  = dmws_pkg::OP_STRIKE;
                    wr_addr = cell_addr(RowW'(srow_reg), RowW'(scol_reg));
                end
                state_next = ST_PROBE;
            end
            ST_RS0:
            begin
                addr_prev  = cell_addr(row_reg, ZERO);
                state_next = ST_RS1;
            end
            ST_RS1:
            begin
                addr_prev  = cell_addr(row_reg, ONE);
                cmd.op     = dmws_pkg::OP_WEST;
                state_next = ST_RS2;
            end
            ST_RS2:
            begin
                cmd.op     = dmws_pkg::OP_CENTER;
                col_next   = ONE;
                state_next = ST_C0;
            end
            ST_C0:
            begin
                addr_prev  = cell_addr(row_reg - ONE, col_reg);
                addr_new   = cell_addr(row_reg, col_reg);
                state_next = ST_C1;
            end
            ST_C1:
            begin
                addr_prev  = cell_addr(row_reg + ONE, col_reg);
                cmd.op     = dmws_pkg::OP_CAP_N;
                state_next = ST_C2;
            end
            ST_C2:
            begin
                addr_prev  = cell_addr(row_reg, col_reg + ONE);
                cmd.op     = dmws_pkg::OP_CAP_S;
                state_next = ST_C3;
            end
            ST_C3:
            begin
                cmd.op     = dmws_pkg::OP_CAP_E;
                state_next = ST_C4;
            end
            ST_C4:
            begin
                cmd.op     = dmws_pkg::OP_NUM;
                state_next = ST_C5;
            end
            ST_C5:
            begin
                cmd.op     = dmws_pkg::OP_MUL_LO;
                state_next = ST_C6;
            end
            ST_C6:
            begin
                cmd.op     = dmws_pkg::OP_MUL_HI;
                state_next = ST_C7;
            end
            ST_C7:
            begin
                cmd.op  = dmws_pkg::OP_WR_CELL;
                wr_addr = cell_addr(row_reg, col_reg);
                if (col_reg == INNER_LAST)
                begin
                    if (row_reg == INNER_LAST)
                    begin
                        side_next  = SIDE_TOP;
                        col_next   = ONE;
                        state_next = ST_E0;
                    end
                    else
                    begin
                        row_next   = row_reg + ONE;
                        state_next = ST_RS0;
                    end
                end
                else
                begin
                    col_next   = col_reg + ONE;
                    state_next = ST_C0;
                end
            end
            ST_E0:
            begin
                addr_new   = cell_addr(src_r, src_c);
                state_next = ST_E1;
            end
            ST_E1:
            begin
                cmd.op     = dmws_pkg::OP_EDGE_MUL;
                state_next = ST_E2;
            end
            ST_E2:
            begin
                cmd.op     = dmws_pkg::OP_EDGE_WR;
                wr_addr    = cell_addr(dst_r, dst_c);
                state_next = ST_E0;
                if (side_reg == SIDE_CORNER)
                begin
                    if (col_reg == LAST_CORNER)
                    begin
                        state_next = ST_SWAP;
                    end
                    else
                    begin
                        col_next = col_reg + ONE;
                    end
                end
                else if (col_reg == INNER_LAST)
                begin
                    col_next = ONE;
                    case (side_reg)
                        SIDE_TOP:   side_next = SIDE_BOT;
                        SIDE_BOT:   side_next = SIDE_LEFT;
                        SIDE_LEFT:  side_next = SIDE_RIGHT;
                        default:
                        begin
                            side_next = SIDE_CORNER;
                            col_next  = ZERO;
                        end
                    endcase
                end
                else
                begin
                    col_next = col_reg + ONE;
                end
            end
            ST_SWAP:
            begin
                cmd.op     = dmws_pkg::OP_SWAP;
                state_next = ST_PROBE;
            end
            ST_PROBE:
            begin
                cmd.rd_probe = 1'b1;
                state_next   = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.rd_probe = 1'b1;
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = dmws_pkg::OP_RESULT;
                    cmd.zero       = strike_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            side_reg      <= SIDE_TOP;
            row_reg       <= '0;
            col_reg       <= '0;
            cnt_reg       <= '0;
            strike_reg    <= 1'b0;
            srow_reg      <= '0;
            scol_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            side_reg      <= side_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            cnt_reg       <= cnt_next;
            strike_reg    <= strike_next;
            srow_reg      <= srow_next;
            scol_reg      <= scol_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// ===== src/drum_membrane_wave_step_unit.sv =====
// top level of the membrane wave step unit
//
// channel  direction  handshake              payload
// in       request    in_valid / in_ready    kind, strike_row, strike_col, strike_value
// out      result     out_valid / out_ready  probe_value, saturated
// cfg      write      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// step request: interior cells are worked one at a time through states C0 to C7,
// paced by the shared multiplier and one ram read port
// strike request: both grid banks are cleared one cell per cycle
// after reset a clearing pass over all N*N cells runs before in_ready rises
// a finished result waits in the output register; the next request may enter meanwhile
`timescale 1ns / 1ps
`default_nettype none
module drum_membrane_wave_step_unit #(
    parameter int GridSize = dmws_pkg::GRID_SIZE
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               kind,
    input  wire logic [dmws_pkg::POS_W-1:0]         strike_row,
    input  wire logic [dmws_pkg::POS_W-1:0]         strike_col,
    input  wire logic signed [dmws_pkg::DATA_W-1:0] strike_value,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [dmws_pkg::DATA_W-1:0]      probe_value,
    output logic                                    saturated,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [dmws_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dmws_pkg::COEF_W-1:0]        cfg_data
);

    localparam int AddrW = $clog2(GridSize * GridSize);

    dmws_pkg::dp_cmd_t cmd;
    logic [AddrW-1:0]  addr_prev, addr_new, wr_addr;

    assign cfg_ready = 1'b1;

    dmws_ctrl #(
        .GridSize(GridSize)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .strike_row (strike_row),
        .strike_col (strike_col),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cmd        (cmd),
        .addr_prev  (addr_prev),
        .addr_new   (addr_new),
        .wr_addr    (wr_addr)
    );

    dmws_dp #(
        .GridSize(GridSize)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .addr_prev    (addr_prev),
        .addr_new     (addr_new),
        .wr_addr      (wr_addr),
        .strike_value (strike_value),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .probe_value  (probe_value),
        .saturated    (saturated)
    );

endmodule
`default_nettype wire

// ===== src/dmws_checker.sv =====
// port level checks for the membrane wave step unit
`timescale 1ns / 1ps
`default_nettype none
`include "drum_membrane_wave_step_unit_defines.svh"
module dmws_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               in_valid,
    input wire logic                               in_ready,
    input wire logic                               out_valid,
    input wire logic                               out_ready,
    input wire logic signed [dmws_pkg::DATA_W-1:0] probe_value,
    input wire logic                               saturated
);

    // a stalled result holds its payload
    `DMWS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(probe_value) && $stable(saturated), "result changed while stalled")

    // an accepted request keeps the unit busy on the next cycle
    `DMWS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
        "unit ready right after accepting a request")

    // a new result appears only at the end of a busy period
    `DMWS_ASSERT_NOW(a_result_after_work, $rose(out_valid), $past(!in_ready),
        "result raised without work in progress")

endmodule

bind drum_membrane_wave_step_unit dmws_checker u_dmws_checker (.*);
`default_nettype wire
